// ===== design/lslf_pkg.sv =====
// ----------------------------------------------------------------------------
// Least-squares line fit: shared types and constants
// Command and status records between the controller and the datapath, the
// controller state encoding, operand selectors and result codes.
// ----------------------------------------------------------------------------
package lslf_pkg;

   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned RESULT_W    = 32;
   localparam int unsigned MIN_POINTS  = 2;
   localparam int unsigned SLOPE_SHIFT = 16;
   localparam int unsigned ICPT_SHIFT  = 8;

   localparam logic [RESULT_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [RESULT_W-1:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      FIT_OK   = 2'd0,
      FIT_FEW  = 2'd1,
      FIT_FLAT = 2'd2,
      FIT_MANY = 2'd3
   } fit_status_type;

   typedef enum logic [1:0] {
      A_SXX = 2'd0,
      A_SXY = 2'd1,
      A_SX  = 2'd2
   } mul_a_sel_type;

   typedef enum logic [1:0] {
      B_N  = 2'd0,
      B_SX = 2'd1,
      B_SY = 2'd2
   } mul_b_sel_type;

   typedef enum logic [4:0] {
      ST_ACCUM,
      ST_D1_GO,
      ST_D1_RUN,
      ST_D2_GO,
      ST_D2_RUN,
      ST_D_TEST,
      ST_S1_GO,
      ST_S1_RUN,
      ST_S2_GO,
      ST_S2_RUN,
      ST_SDIV_GO,
      ST_SDIV_RUN,
      ST_I1_GO,
      ST_I1_RUN,
      ST_I2_GO,
      ST_I2_RUN,
      ST_IDIV_GO,
      ST_IDIV_RUN,
      ST_FINISH
   } fit_state_type;

   typedef struct packed {
      logic           acc_en;
      logic           clear_sums;
      logic           mul_start;
      logic           mul_first;
      logic           mul_minus;
      mul_a_sel_type  mul_a_sel;
      mul_b_sel_type  mul_b_sel;
      logic           load_d;
      logic           div_start;
      logic           div_icpt;
      logic           store_slope;
      logic           store_icpt;
      logic           load_out;
      fit_status_type out_status;
   } lslf_cmd_type;

   typedef struct packed {
      logic ovf;
      logic few;
      logic mul_busy;
      logic div_busy;
      logic acc_zero;
   } lslf_sts_type;

endpackage

// ===== design/lslf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Least-squares line fit: controller
// Accepts words while accumulating, then sequences the six products and the
// two divisions of the fit and hands the result to the output register.
// ----------------------------------------------------------------------------
module lslf_ctrl
   import lslf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tlast,
   output logic         req_tready,
   input  logic         rsp_tready,
   output logic         rsp_tvalid,
   input  lslf_sts_type sts,
   output lslf_cmd_type cmd
);

   fit_state_type  state_ff, state_in;
   fit_status_type status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACCUM;
         status_ff    <= FIT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_ACCUM: begin
            if (req_tvalid && req_tlast) state_in = ST_D1_GO;
         end
         ST_D1_GO: begin
            if (sts.ovf || sts.few) state_in = ST_FINISH;
            else                    state_in = ST_D1_RUN;
         end
         ST_D1_RUN:   if (!sts.mul_busy) state_in = ST_D2_GO;
         ST_D2_GO:    state_in = ST_D2_RUN;
         ST_D2_RUN:   if (!sts.mul_busy) state_in = ST_D_TEST;
         ST_D_TEST: begin
            if (sts.acc_zero) state_in = ST_FINISH;
            else              state_in = ST_S1_GO;
         end
         ST_S1_GO:    state_in = ST_S1_RUN;
         ST_S1_RUN:   if (!sts.mul_busy) state_in = ST_S2_GO;
         ST_S2_GO:    state_in = ST_S2_RUN;
         ST_S2_RUN:   if (!sts.mul_busy) state_in = ST_SDIV_GO;
         ST_SDIV_GO:  state_in = ST_SDIV_RUN;
         ST_SDIV_RUN: if (!sts.div_busy) state_in = ST_I1_GO;
         ST_I1_GO:    state_in = ST_I1_RUN;
         ST_I1_RUN:   if (!sts.mul_busy) state_in = ST_I2_GO;
         ST_I2_GO:    state_in = ST_I2_RUN;
         ST_I2_RUN:   if (!sts.mul_busy) state_in = ST_IDIV_GO;
         ST_IDIV_GO:  state_in = ST_IDIV_RUN;
         ST_IDIV_RUN: if (!sts.div_busy) state_in = ST_FINISH;
         ST_FINISH:   if (out_free) state_in = ST_ACCUM;
         default:     state_in = ST_ACCUM;
      endcase
   end

   always_comb begin
      cmd        = '0;
      status_in  = status_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_ACCUM: begin
            req_tready = 1'b1;
            cmd.acc_en = req_tvalid;
         end
         ST_D1_GO: begin
            // Error cases are known before any arithmetic starts.
            if (sts.ovf)      status_in = FIT_MANY;
            else if (sts.few) status_in = FIT_FEW;
            else              status_in = FIT_OK;
            cmd.mul_start = !(sts.ovf || sts.few);
            cmd.mul_first = 1'b1;
            cmd.mul_a_sel = A_SXX;
            cmd.mul_b_sel = B_N;
         end
         ST_D2_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_minus = 1'b1;
            cmd.mul_a_sel = A_SX;
            cmd.mul_b_sel = B_SX;
         end
         ST_D_TEST: begin
            cmd.load_d = 1'b1;
            if (sts.acc_zero) status_in = FIT_FLAT;
         end
         ST_S1_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_first = 1'b1;
            cmd.mul_a_sel = A_SXY;
            cmd.mul_b_sel = B_N;
         end
         ST_S2_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_minus = 1'b1;
            cmd.mul_a_sel = A_SX;
            cmd.mul_b_sel = B_SY;
         end
         ST_SDIV_GO:  cmd.div_start   = 1'b1;
         ST_SDIV_RUN: cmd.store_slope = !sts.div_busy;
         ST_I1_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_first = 1'b1;
            cmd.mul_a_sel = A_SXX;
            cmd.mul_b_sel = B_SY;
         end
         ST_I2_GO: begin
            cmd.mul_start = 1'b1;
            cmd.mul_minus = 1'b1;
            cmd.mul_a_sel = A_SXY;
            cmd.mul_b_sel = B_SX;
         end
         ST_IDIV_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_icpt  = 1'b1;
         end
         ST_IDIV_RUN: cmd.store_icpt = !sts.div_busy;
         ST_FINISH: begin
            cmd.load_out   = out_free;
            cmd.clear_sums = out_free;
            cmd.out_status = status_ff;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_out)     rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
      else                  rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== design/lslf_dp.sv =====
// ----------------------------------------------------------------------------
// Least-squares line fit: datapath
// Running sums, a shift-and-add multiplier with accumulator, a restoring
// divider with saturation, and the output register.
// ----------------------------------------------------------------------------
module lslf_dp
   import lslf_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 1024
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic signed [SAMPLE_W-1:0] x_sample,
   input  logic signed [SAMPLE_W-1:0] y_sample,
   input  lslf_cmd_type               cmd,
   output lslf_sts_type               sts,
   output logic [RESULT_W-1:0]        rsp_slope,
   output logic [RESULT_W-1:0]        rsp_intercept,
   output fit_status_type             rsp_status
);

   localparam int unsigned CW   = $clog2(MAX_POINTS + 1);
   localparam int unsigned SW   = SAMPLE_W + CW;
   localparam int unsigned QW   = 2 * SAMPLE_W - 1 + CW;
   localparam int unsigned AW   = QW + SW + 1;
   localparam int unsigned DMW  = 2 * SAMPLE_W + 2 * CW;
   localparam int unsigned NUMW = AW + ICPT_SHIFT;
   localparam int unsigned XW   = AW + SLOPE_SHIFT;
   localparam int unsigned DCW  = $clog2(NUMW + 1);

   // Running sums
   logic [CW-1:0]           count_ff, count_in;
   logic                    ovf_ff, ovf_in;
   logic signed [SW-1:0]    sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic signed [QW-1:0]    sum_xx_ff, sum_xx_in, sum_xy_ff, sum_xy_in;
   logic signed [2*SAMPLE_W-1:0] prod_xx, prod_xy;

   assign prod_xx = x_sample * x_sample;
   assign prod_xy = x_sample * y_sample;

   always_comb begin
      count_in  = count_ff;
      ovf_in    = ovf_ff;
      sum_x_in  = sum_x_ff;
      sum_y_in  = sum_y_ff;
      sum_xx_in = sum_xx_ff;
      sum_xy_in = sum_xy_ff;
      if (cmd.clear_sums) begin
         count_in  = '0;
         ovf_in    = 1'b0;
         sum_x_in  = '0;
         sum_y_in  = '0;
         sum_xx_in = '0;
         sum_xy_in = '0;
      end else if (cmd.acc_en) begin
         if (!ovf_ff && (count_ff < CW'(MAX_POINTS))) begin
            count_in  = count_ff + 1'b1;
            sum_x_in  = sum_x_ff + SW'(x_sample);
            sum_y_in  = sum_y_ff + SW'(y_sample);
            sum_xx_in = sum_xx_ff + QW'(prod_xx);
            sum_xy_in = sum_xy_ff + QW'(prod_xy);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         ovf_ff    <= 1'b0;
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_xx_ff <= '0;
         sum_xy_ff <= '0;
      end else begin
         count_ff  <= count_in;
         ovf_ff    <= ovf_in;
         sum_x_ff  <= sum_x_in;
         sum_y_ff  <= sum_y_in;
         sum_xx_ff <= sum_xx_in;
         sum_xy_ff <= sum_xy_in;
      end
   end

   // Shift-and-add multiplier. The multiplier operand is taken as a magnitude
   // and its sign folded into the multiplicand together with the term's sign.
   logic signed [QW-1:0] a_src;
   logic signed [SW-1:0] b_src;
   logic signed [AW-1:0] a_ext, a_load;
   logic [SW-1:0]        b_mag;
   logic signed [AW-1:0] mul_a_ff, mul_a_in, acc_ff, acc_in;
   logic [SW-1:0]        mul_b_ff, mul_b_in;

   always_comb begin
      unique case (cmd.mul_a_sel)
         A_SXX:   a_src = sum_xx_ff;
         A_SXY:   a_src = sum_xy_ff;
         A_SX:    a_src = QW'(sum_x_ff);
         default: a_src = '0;
      endcase
      unique case (cmd.mul_b_sel)
         B_N:     b_src = $signed(SW'(count_ff));
         B_SX:    b_src = sum_x_ff;
         B_SY:    b_src = sum_y_ff;
         default: b_src = '0;
      endcase
      a_ext  = AW'(a_src);
      b_mag  = b_src[SW-1] ? $unsigned(-b_src) : $unsigned(b_src);
      a_load = (b_src[SW-1] ^ cmd.mul_minus) ? -a_ext : a_ext;
   end

   always_comb begin
      mul_a_in = mul_a_ff;
      mul_b_in = mul_b_ff;
      acc_in   = acc_ff;
      if (cmd.mul_start) begin
         mul_a_in = a_load;
         mul_b_in = b_mag;
         if (cmd.mul_first) acc_in = '0;
      end else if (mul_b_ff != '0) begin
         if (mul_b_ff[0]) acc_in = acc_ff + mul_a_ff;
         mul_a_in = mul_a_ff <<< 1;
         mul_b_in = mul_b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) mul_b_ff <= '0;
      else       mul_b_ff <= mul_b_in;
   end

   always_ff @(posedge clock) begin
      mul_a_ff <= mul_a_in;
      acc_ff   <= acc_in;
   end

   // Restoring divider: one quotient bit a cycle over the numerator magnitude.
   // Bits pushed out of the top of the quotient only matter for saturation.
   logic [DMW-1:0]      d_ff;
   logic signed [XW-1:0] num_ext, num_shifted, num_mag;
   logic [NUMW-1:0]     num_ff, num_in;
   logic [DMW-1:0]      rem_ff, rem_in;
   logic [DMW:0]        rem_wide, rem_sub;
   logic                rem_ge;
   logic [RESULT_W-1:0] q_ff, q_in;
   logic                sticky_ff, sticky_in, neg_ff, neg_in;
   logic [DCW-1:0]      dcnt_ff, dcnt_in;
   logic                q_big;
   logic [RESULT_W-1:0] div_result;

   always_comb begin
      num_ext     = XW'(acc_ff);
      num_shifted = cmd.div_icpt ? (num_ext <<< ICPT_SHIFT) : (num_ext <<< SLOPE_SHIFT);
      num_mag     = num_shifted[XW-1] ? -num_shifted : num_shifted;
      rem_wide    = {rem_ff, num_ff[NUMW-1]};
      rem_sub     = rem_wide - {1'b0, d_ff};
      rem_ge      = (rem_wide >= {1'b0, d_ff});
   end

   always_comb begin
      num_in    = num_ff;
      rem_in    = rem_ff;
      q_in      = q_ff;
      sticky_in = sticky_ff;
      neg_in    = neg_ff;
      dcnt_in   = dcnt_ff;
      if (cmd.div_start) begin
         num_in    = num_mag[NUMW-1:0];
         neg_in    = acc_ff[AW-1];
         rem_in    = '0;
         q_in      = '0;
         sticky_in = 1'b0;
         dcnt_in   = DCW'(NUMW);
      end else if (dcnt_ff != '0) begin
         num_in    = num_ff << 1;
         rem_in    = rem_ge ? rem_sub[DMW-1:0] : rem_wide[DMW-1:0];
         q_in      = {q_ff[RESULT_W-2:0], rem_ge};
         sticky_in = sticky_ff | q_ff[RESULT_W-1];
         dcnt_in   = dcnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dcnt_ff <= '0;
      else       dcnt_ff <= dcnt_in;
   end

   always_ff @(posedge clock) begin
      num_ff    <= num_in;
      rem_ff    <= rem_in;
      q_ff      <= q_in;
      sticky_ff <= sticky_in;
      neg_ff    <= neg_in;
      if (cmd.load_d) d_ff <= acc_ff[DMW-1:0];
   end

   always_comb begin
      q_big = sticky_ff | q_ff[RESULT_W-1];
      if (neg_ff) div_result = q_big ? SAT_NEG : (~q_ff + 1'b1);
      else        div_result = q_big ? SAT_POS : q_ff;
   end

   // Fit results and the output register
   logic [RESULT_W-1:0] slope_res_ff, icpt_res_ff;
   logic [RESULT_W-1:0] rsp_slope_ff, rsp_icpt_ff;
   fit_status_type      rsp_status_ff;

   always_ff @(posedge clock) begin
      if (cmd.store_slope) slope_res_ff <= div_result;
      if (cmd.store_icpt)  icpt_res_ff  <= div_result;
      if (cmd.load_out) begin
         rsp_slope_ff  <= (cmd.out_status == FIT_OK) ? slope_res_ff : '0;
         rsp_icpt_ff   <= (cmd.out_status == FIT_OK) ? icpt_res_ff : '0;
         rsp_status_ff <= cmd.out_status;
      end
   end

   assign rsp_slope     = rsp_slope_ff;
   assign rsp_intercept = rsp_icpt_ff;
   assign rsp_status    = rsp_status_ff;

   assign sts.ovf      = ovf_ff;
   assign sts.few      = (count_ff < CW'(MIN_POINTS));
   assign sts.mul_busy = (mul_b_ff != '0);
   assign sts.div_busy = (dcnt_ff != '0);
   assign sts.acc_zero = (acc_ff == '0);

endmodule

// ===== design/least_squares_line_fit.sv =====
// ----------------------------------------------------------------------------
// Least-squares line fit
// Fits y = slope * x + intercept over a run of Q8.8 sample pairs and returns
// slope and intercept in Q16.16 with a status word at the end of each run.
//
//   Channel  Direction  Word contents
//   req      in         tdata: x_sample [15:0], y_sample [31:16]; tlast: last_pair
//   rsp      out        tdata: slope [31:0], intercept [63:32]; tuser: fit_status
//
// Sample pairs are accepted one per cycle while the block is accumulating.
// After the pair marked last the fit runs: six multiplications, each stepping
// through the significant bits of its multiplier operand, then two divisions
// on the shared one-bit-a-cycle divider. Error runs finish without any
// arithmetic, and a zero x spread ends the fit after the two products of the
// denominator. Reset clears all sums at once. While rsp_tready is low the
// result holds and the next run is still accumulated and fitted; only its
// hand-over to the output waits, and intake pauses until then.
// ----------------------------------------------------------------------------
module least_squares_line_fit
   import lslf_pkg::*;
#(
   parameter int unsigned MAX_POINTS = 1024
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_sample [15:0], y_sample [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // slope [31:0], intercept [63:32]
   output logic [1:0]  rsp_tuser    // fit_status [1:0]
);

   lslf_cmd_type        cmd;
   lslf_sts_type        sts;
   logic [RESULT_W-1:0] rsp_slope, rsp_intercept;
   fit_status_type      rsp_status;

   lslf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .sts        (sts),
      .cmd        (cmd)
   );

   lslf_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .x_sample      (req_tdata[15:0]),
      .y_sample      (req_tdata[31:16]),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_slope     (rsp_slope),
      .rsp_intercept (rsp_intercept),
      .rsp_status    (rsp_status)
   );

   assign rsp_tdata = {rsp_intercept, rsp_slope};
   assign rsp_tuser = rsp_status;

`ifndef SYNTHESIS
   // The word that closes a run starts the fit, so intake must pause.
   a_last_stops_intake: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !req_tready)
      else $error("word accepted in the cycle after the last word of a run");

   // A failed fit must not leak stale quotients.
   a_error_zeroes_fit: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser != FIT_OK)) |-> (rsp_tdata == '0))
      else $error("non-zero slope or intercept reported with an error status");

   // The multiplier and the divider share the accumulator and never overlap.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sts.mul_busy && sts.div_busy))
      else $error("multiplier and divider busy at the same time");

   // The output word is loaded only when the previous one has gone or is going.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_tvalid || rsp_tready))
      else $error("result word overwritten before it was taken");
`endif

endmodule
